// ===== design/hsc_pkg.sv =====
`timescale 1ns / 1ps

package hsc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALL,
        ST_MUL_I,
        ST_ACC,
        ST_MUL_P,
        ST_MUL_G,
        ST_SUM,
        ST_DONE
    } hsc_state_t;

    typedef enum logic [1:0] {
        MODE_FORWARD   = 2'd0,
        MODE_BACKWARD  = 2'd1,
        MODE_BRAKE     = 2'd2,
        MODE_FREEWHEEL = 2'd3
    } hsc_mode_t;

    typedef enum logic [1:0] {
        REG_DRIVE_MODE = 2'd0,
        REG_PROP_GAIN  = 2'd1,
        REG_INTEG_GAIN = 2'd2
    } hsc_reg_idx_t;

    localparam int GAIN_W   = 24;
    localparam int DUTY_W   = 10;
    localparam int CUR_W    = 16;
    localparam int ERR_W    = 17;
    localparam int INTEG_W  = 28;
    localparam int PROD_W   = 53;
    localparam int SUM_W    = 58;

    localparam logic [DUTY_W-1:0]         DUTY_MAX    = 10'd1023;
    localparam logic signed [24:0]        INTEG_STEP  = 25'sd177;
    localparam logic signed [INTEG_W:0]   INTEG_LIMIT = 29'sd83886080;
    localparam logic [3:0]                PREV_HALL_RESET = 4'd7;

    typedef struct packed {
        logic [2:0]              step;
        logic [3:0]              prev_hall;
        logic [2:0]              hall_idx;
        logic [DUTY_W-1:0]       compare_u;
        logic [DUTY_W-1:0]       compare_v;
        logic [DUTY_W-1:0]       compare_w;
        logic [2:0]              enable;
        logic [1:0]              sense_sel;
    } hsc_comm_t;

    // raw levels to hall index, all low and all high are faults
    function automatic logic [2:0] hall_decode(input logic [2:0] raw);
        logic [2:0] idx;
        case (raw)
            3'd0: idx = 3'd7;
            3'd1: idx = 3'd0;
            3'd2: idx = 3'd2;
            3'd3: idx = 3'd1;
            3'd4: idx = 3'd4;
            3'd5: idx = 3'd5;
            3'd6: idx = 3'd3;
            default: idx = 3'd6;
        endcase
        return idx;
    endfunction

    // value below 18
    function automatic logic [2:0] mod6(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd12) begin
            r = v - 5'd12;
        end else if (v >= 5'd6) begin
            r = v - 5'd6;
        end else begin
            r = v;
        end
        return r[2:0];
    endfunction

endpackage

// ===== design/hsc_commute.sv =====
`timescale 1ns / 1ps

module hsc_commute (
    input  logic [2:0]                  hall_bits,
    input  logic [1:0]                  drive_mode,
    input  hsc_pkg::hsc_comm_t          cur,
    input  logic [hsc_pkg::DUTY_W-1:0]  duty,
    output hsc_pkg::hsc_comm_t          nxt
);
    import hsc_pkg::*;

    logic [2:0]        idx;
    logic signed [4:0] diff;
    logic signed [4:0] rem;
    logic [2:0]        step;
    logic [1:0]        hi_ph;
    logic [1:0]        lo_ph;
    logic [1:0]        ch;
    logic              apply;
    logic              step_ok;
    logic [DUTY_W-1:0] cmp [3];

    always_comb begin
        idx  = hall_decode(hall_bits);
        diff = $signed({2'b00, idx}) - $signed({1'b0, cur.prev_hall});
        if (diff >= 5'sd6) begin
            rem = diff - 5'sd6;
        end else if (diff <= -5'sd6) begin
            rem = diff + 5'sd6;
        end else begin
            rem = diff;
        end

        nxt          = cur;
        nxt.hall_idx = idx;
        step         = cur.step;
        apply        = 1'b1;
        case (hsc_mode_t'(drive_mode))
            MODE_FORWARD: begin
                step = mod6({2'b00, idx} + 5'd2);
            end
            MODE_BACKWARD: begin
                step = mod6({2'b00, idx} + 5'd4);
            end
            MODE_BRAKE: begin
                if (rem > 5'sd1) begin
                    step = mod6({2'b00, idx} + 5'd5);
                end else if (rem < -5'sd1) begin
                    step          = mod6({2'b00, idx} + 5'd1);
                    nxt.prev_hall = {1'b0, idx};
                end
            end
            default: begin
                apply = 1'b0;
            end
        endcase
        nxt.step = step;

        step_ok = 1'b1;
        case (step)
            3'd0: begin hi_ph = 2'd0; lo_ph = 2'd1; ch = 2'd1; end
            3'd1: begin hi_ph = 2'd0; lo_ph = 2'd2; ch = 2'd2; end
            3'd2: begin hi_ph = 2'd1; lo_ph = 2'd2; ch = 2'd2; end
            3'd3: begin hi_ph = 2'd1; lo_ph = 2'd0; ch = 2'd0; end
            3'd4: begin hi_ph = 2'd2; lo_ph = 2'd0; ch = 2'd0; end
            3'd5: begin hi_ph = 2'd2; lo_ph = 2'd1; ch = 2'd1; end
            default: begin
                hi_ph   = 2'd0;
                lo_ph   = 2'd1;
                ch      = 2'd0;
                step_ok = 1'b0;
            end
        endcase

        cmp[0] = cur.compare_u;
        cmp[1] = cur.compare_v;
        cmp[2] = cur.compare_w;
        if (apply) begin
            if (step_ok) begin
                cmp[hi_ph]    = duty;
                cmp[lo_ph]    = '0;
                nxt.enable    = (3'b001 << hi_ph) | (3'b001 << lo_ph);
                nxt.sense_sel = ch;
            end
        end else begin
            nxt.enable = 3'b000;
        end
        nxt.compare_u = cmp[0];
        nxt.compare_v = cmp[1];
        nxt.compare_w = cmp[2];
    end

endmodule

// ===== design/hall_six_step_commutator_pi.sv =====
`timescale 1ns / 1ps
// channel  | ports                                   | role
// s_       | s_valid s_ready s_op s_hall_bits ...    | hall event or control tick in
// m_       | m_valid m_ready m_compare_u ...         | one result per item out
// cfg_     | cfg_wr_en cfg_index cfg_wr_data         | register write, no wait
// a hall item runs through ST_HALL and ST_DONE, a tick through ST_MUL_I, ST_ACC, ST_MUL_P, ST_MUL_G, ST_SUM, ST_DONE
// the tick runs three products through one shared 28x25 multiplier
// one item at a time; s_ready is high only while the sequencer is idle
// a held result stalls the sequencer in its last state
// reset clears drive state, integrator, duty and handshake

module hall_six_step_commutator_pi (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [hsc_pkg::GAIN_W-1:0]          cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [2:0]                          s_hall_bits,
    input  logic signed [hsc_pkg::CUR_W-1:0]    s_target_current,
    input  logic signed [hsc_pkg::CUR_W-1:0]    s_sense_ch0,
    input  logic signed [hsc_pkg::CUR_W-1:0]    s_sense_ch1,
    input  logic signed [hsc_pkg::CUR_W-1:0]    s_sense_ch2,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hsc_pkg::DUTY_W-1:0]          m_compare_u,
    output logic [hsc_pkg::DUTY_W-1:0]          m_compare_v,
    output logic [hsc_pkg::DUTY_W-1:0]          m_compare_w,
    output logic                                m_enable_u,
    output logic                                m_enable_v,
    output logic                                m_enable_w,
    output logic [hsc_pkg::DUTY_W-1:0]          m_duty_now,
    output logic [2:0]                          m_step_index,
    output logic [2:0]                          m_hall_index
);
    import hsc_pkg::*;

    hsc_state_t                 state_reg, state_next;

    logic [1:0]                 drive_mode_reg;
    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [GAIN_W-1:0]          integ_gain_reg;

    hsc_comm_t                  comm_reg;
    hsc_comm_t                  comm_next;
    logic [DUTY_W-1:0]          duty_reg;
    logic signed [INTEG_W-1:0]  integ_acc_reg;

    logic [2:0]                 hall_bits_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    psum_reg;

    logic                       m_valid_reg;
    hsc_comm_t                  m_comm_reg;
    logic [DUTY_W-1:0]          m_duty_reg;

    logic                       in_xfer;
    logic                       out_free;
    logic signed [CUR_W-1:0]    meas;
    logic signed [INTEG_W-1:0]  mul_a;
    logic signed [24:0]         mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [INTEG_W:0]    acc_sum;
    logic signed [INTEG_W-1:0]  acc_clamped;
    logic signed [SUM_W-1:0]    total;
    logic [SUM_W-33:0]          duty_full;
    logic [DUTY_W-1:0]          duty_calc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    hsc_commute u_commute (
        .hall_bits  (hall_bits_reg),
        .drive_mode (drive_mode_reg),
        .cur        (comm_reg),
        .duty       (duty_reg),
        .nxt        (comm_next)
    );

    always_comb begin
        case (comm_reg.sense_sel)
            2'd1:    meas = s_sense_ch1;
            2'd2:    meas = s_sense_ch2;
            default: meas = s_sense_ch0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_MUL_I: begin
                mul_a = INTEG_W'(err_reg);
                mul_b = INTEG_STEP;
            end
            ST_MUL_G: begin
                mul_a = integ_acc_reg;
                mul_b = $signed({1'b0, integ_gain_reg});
            end
            default: begin
                mul_a = INTEG_W'(err_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        acc_sum = $signed({integ_acc_reg[INTEG_W-1], integ_acc_reg})
                + $signed(prod_reg[INTEG_W:0]);
        if (acc_sum > INTEG_LIMIT) begin
            acc_clamped = INTEG_W'(INTEG_LIMIT);
        end else if (acc_sum < -INTEG_LIMIT) begin
            acc_clamped = INTEG_W'(-INTEG_LIMIT);
        end else begin
            acc_clamped = acc_sum[INTEG_W-1:0];
        end

        total     = psum_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        duty_full = total[SUM_W-1:32];
        if (total <= 0) begin
            duty_calc = '0;
        end else if (duty_full > {{(SUM_W-32-DUTY_W){1'b0}}, DUTY_MAX}) begin
            duty_calc = DUTY_MAX;
        end else begin
            duty_calc = duty_full[DUTY_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = s_op ? ST_MUL_I : ST_HALL;
                end
            end
            ST_HALL:  state_next = ST_DONE;
            ST_MUL_I: state_next = ST_ACC;
            ST_ACC:   state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_G;
            ST_MUL_G: state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg <= MODE_FORWARD;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DRIVE_MODE: drive_mode_reg <= cfg_wr_data[1:0];
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wr_data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comm_reg.step      <= '0;
            comm_reg.prev_hall <= PREV_HALL_RESET;
            comm_reg.hall_idx  <= '0;
            comm_reg.compare_u <= '0;
            comm_reg.compare_v <= '0;
            comm_reg.compare_w <= '0;
            comm_reg.enable    <= '0;
            comm_reg.sense_sel <= '0;
            duty_reg           <= '0;
            integ_acc_reg      <= '0;
        end else begin
            case (state_reg)
                ST_HALL: comm_reg      <= comm_next;
                ST_ACC:  integ_acc_reg <= acc_clamped;
                ST_SUM:  duty_reg      <= duty_calc;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            hall_bits_reg <= s_hall_bits;
            err_reg       <= ERR_W'(s_target_current) - ERR_W'(meas);
        end
        if (state_reg == ST_MUL_I || state_reg == ST_MUL_P || state_reg == ST_MUL_G) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL_G) begin
            psum_reg <= {prod_reg[41:0], 16'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_comm_reg <= comm_reg;
            m_duty_reg <= duty_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_compare_u  = m_comm_reg.compare_u;
    assign m_compare_v  = m_comm_reg.compare_v;
    assign m_compare_w  = m_comm_reg.compare_w;
    assign m_enable_u   = m_comm_reg.enable[0];
    assign m_enable_v   = m_comm_reg.enable[1];
    assign m_enable_w   = m_comm_reg.enable[2];
    assign m_duty_now   = m_duty_reg;
    assign m_step_index = m_comm_reg.step;
    assign m_hall_index = m_comm_reg.hall_idx;

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("item accepted while another is in work");

    a_integ_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed({integ_acc_reg[INTEG_W-1], integ_acc_reg}) <= INTEG_LIMIT) &&
        ($signed({integ_acc_reg[INTEG_W-1], integ_acc_reg}) >= -INTEG_LIMIT))
        else $error("integrator out of range");

    a_enable_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(comm_reg.enable) == 0) || ($countones(comm_reg.enable) == 2))
        else $error("phase enables not a pair");

    a_sense_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        comm_reg.sense_sel != 2'd3)
        else $error("unused sense select");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hsc_pkg::*;

    localparam longint INTEG_MAX = 64'sd1280 * 64'sd65536;

    typedef struct packed {
        logic        op;
        logic [2:0]  hall_bits;
        logic [15:0] target;
        logic [15:0] sense0;
        logic [15:0] sense1;
        logic [15:0] sense2;
    } motor_item_t;

    typedef struct packed {
        logic [9:0] cmp_u;
        logic [9:0] cmp_v;
        logic [9:0] cmp_w;
        logic       en_u;
        logic       en_v;
        logic       en_w;
        logic [9:0] duty;
        logic [2:0] step;
        logic [2:0] hall_idx;
    } drive_out_t;

    class drive_scoreboard;
        hsc_mode_t   mode;
        logic [23:0] kp;
        logic [23:0] ki;
        logic [2:0]  step;
        logic [3:0]  brake_ref;
        logic [9:0]  duty;
        logic [1:0]  sense_sel;
        int          integ;
        logic [9:0]  cmp [3];
        logic [2:0]  en;
        logic [2:0]  hall_idx;
        drive_out_t  expected_drive_q [$];
        int          errors;

        function new();
            mode = MODE_FORWARD;
            kp = '0;
            ki = '0;
            step = '0;
            brake_ref = 4'd7;
            duty = '0;
            sense_sel = '0;
            integ = 0;
            cmp[0] = '0;
            cmp[1] = '0;
            cmp[2] = '0;
            en = '0;
            hall_idx = '0;
            errors = 0;
        endfunction

        function void write_reg(hsc_reg_idx_t idx, logic [23:0] data);
            case (idx)
                REG_DRIVE_MODE: mode = hsc_mode_t'(data[1:0]);
                REG_PROP_GAIN:  kp = data;
                REG_INTEG_GAIN: ki = data;
                default: ;
            endcase
        endfunction

        // driven phase gets the duty, return phase zero, third phase off
        function void load_step();
            case (step)
                3'd0: begin
                    cmp[0] = duty; cmp[1] = '0; en = 3'b011; sense_sel = 2'd1;
                end
                3'd1: begin
                    cmp[0] = duty; cmp[2] = '0; en = 3'b101; sense_sel = 2'd2;
                end
                3'd2: begin
                    cmp[1] = duty; cmp[2] = '0; en = 3'b110; sense_sel = 2'd2;
                end
                3'd3: begin
                    cmp[0] = '0; cmp[1] = duty; en = 3'b011; sense_sel = 2'd0;
                end
                3'd4: begin
                    cmp[0] = '0; cmp[2] = duty; en = 3'b101; sense_sel = 2'd0;
                end
                3'd5: begin
                    cmp[1] = '0; cmp[2] = duty; en = 3'b110; sense_sel = 2'd1;
                end
                default: ;
            endcase
        endfunction

        function void hall_event(logic [2:0] raw);
            int idx;
            int r;
            case (raw)
                3'd0: idx = 7;
                3'd1: idx = 0;
                3'd2: idx = 2;
                3'd3: idx = 1;
                3'd4: idx = 4;
                3'd5: idx = 5;
                3'd6: idx = 3;
                default: idx = 6;
            endcase
            hall_idx = 3'(idx);
            case (mode)
                MODE_FORWARD: begin
                    step = 3'((idx + 2) % 6);
                    load_step();
                end
                MODE_BACKWARD: begin
                    step = 3'((idx + 4) % 6);
                    load_step();
                end
                MODE_BRAKE: begin
                    r = (idx - int'(brake_ref)) % 6;
                    if (r > 1) begin
                        step = 3'((idx + 5) % 6);
                    end else if (r < -1) begin
                        step = 3'((idx + 1) % 6);
                        brake_ref = 4'(idx);
                    end
                    load_step();
                end
                default: en = 3'b000;
            endcase
        endfunction

        function void control_tick(motor_item_t it);
            longint meas;
            longint err;
            longint acc;
            longint s;
            case (sense_sel)
                2'd1: meas = $signed(it.sense1);
                2'd2: meas = $signed(it.sense2);
                default: meas = $signed(it.sense0);
            endcase
            err = longint'($signed(it.target)) - meas;
            acc = longint'(integ) + err * 177;
            if (acc > INTEG_MAX) acc = INTEG_MAX;
            if (acc < -INTEG_MAX) acc = -INTEG_MAX;
            integ = int'(acc);
            s = err * longint'(kp) * 65536 + acc * longint'(ki);
            if (s <= 0) begin
                duty = '0;
            end else begin
                s = s >>> 32;
                duty = (s > 1023) ? 10'd1023 : 10'(s);
            end
        endfunction

        function void note_transfer(motor_item_t it);
            drive_out_t want;
            if (it.op == 1'b0) hall_event(it.hall_bits);
            else control_tick(it);
            want.cmp_u = cmp[0];
            want.cmp_v = cmp[1];
            want.cmp_w = cmp[2];
            want.en_u = en[0];
            want.en_v = en[1];
            want.en_w = en[2];
            want.duty = duty;
            want.step = step;
            want.hall_idx = hall_idx;
            expected_drive_q.push_back(want);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_drive(drive_out_t got);
            drive_out_t want;
            if (expected_drive_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            want = expected_drive_q.pop_front();
            check_field("compare_u", want.cmp_u, got.cmp_u);
            check_field("compare_v", want.cmp_v, got.cmp_v);
            check_field("compare_w", want.cmp_w, got.cmp_w);
            check_field("enable_u", want.en_u, got.en_u);
            check_field("enable_v", want.en_v, got.en_v);
            check_field("enable_w", want.en_w, got.en_w);
            check_field("duty_now", want.duty, got.duty);
            check_field("step_index", want.step, got.step);
            check_field("hall_index", want.hall_idx, got.hall_idx);
        endfunction

        function int pending();
            return expected_drive_q.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [1:0]               cfg_index;
    logic [GAIN_W-1:0]        cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_op;
    logic [2:0]               s_hall_bits;
    logic signed [CUR_W-1:0]  s_target_current;
    logic signed [CUR_W-1:0]  s_sense_ch0;
    logic signed [CUR_W-1:0]  s_sense_ch1;
    logic signed [CUR_W-1:0]  s_sense_ch2;
    logic                     m_valid;
    logic                     m_ready;
    logic [DUTY_W-1:0]        m_compare_u;
    logic [DUTY_W-1:0]        m_compare_v;
    logic [DUTY_W-1:0]        m_compare_w;
    logic                     m_enable_u;
    logic                     m_enable_v;
    logic                     m_enable_w;
    logic [DUTY_W-1:0]        m_duty_now;
    logic [2:0]               m_step_index;
    logic [2:0]               m_hall_index;

    bit calm;
    drive_scoreboard sb;

    hall_six_step_commutator_pi uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_hall_bits      (s_hall_bits),
        .s_target_current (s_target_current),
        .s_sense_ch0      (s_sense_ch0),
        .s_sense_ch1      (s_sense_ch1),
        .s_sense_ch2      (s_sense_ch2),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_compare_u      (m_compare_u),
        .m_compare_v      (m_compare_v),
        .m_compare_w      (m_compare_w),
        .m_enable_u       (m_enable_u),
        .m_enable_v       (m_enable_v),
        .m_enable_w       (m_enable_w),
        .m_duty_now       (m_duty_now),
        .m_step_index     (m_step_index),
        .m_hall_index     (m_hall_index)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_drive({m_compare_u, m_compare_v, m_compare_w,
                            m_enable_u, m_enable_v, m_enable_w,
                            m_duty_now, m_step_index, m_hall_index});
        end
    end

    function automatic motor_item_t hall_item(logic [2:0] raw);
        motor_item_t it;
        it.op = 1'b0;
        it.hall_bits = raw;
        it.target = 16'($urandom());
        it.sense0 = 16'($urandom());
        it.sense1 = 16'($urandom());
        it.sense2 = 16'($urandom());
        return it;
    endfunction

    function automatic motor_item_t tick_item(logic [15:0] target, logic [15:0] s0,
                                              logic [15:0] s1, logic [15:0] s2);
        motor_item_t it;
        it.op = 1'b1;
        it.hall_bits = 3'($urandom());
        it.target = target;
        it.sense0 = s0;
        it.sense1 = s1;
        it.sense2 = s2;
        return it;
    endfunction

    // mostly small errors around the target so the duty lands mid range
    function automatic logic [15:0] current_near(int base);
        int v;
        if ($urandom_range(0, 9) < 3) return 16'($urandom());
        v = $urandom_range(0, 600);
        return 16'(base + v - 300);
    endfunction

    function automatic motor_item_t random_tick();
        int base;
        base = $urandom_range(0, 4000);
        base -= 2000;
        return tick_item(current_near(base), current_near(base),
                         current_near(base), current_near(base));
    endfunction

    function automatic logic [2:0] raw_for_index(int idx);
        case (idx)
            0: return 3'd1;
            1: return 3'd3;
            2: return 3'd2;
            3: return 3'd6;
            4: return 3'd4;
            default: return 3'd5;
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1 << 14, 1 << 18));
            3: return 24'($urandom());
            default: return 24'($urandom_range(0, 1 << 16));
        endcase
    endfunction

    task automatic send_item(motor_item_t it);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= it.op;
        s_hall_bits <= it.hall_bits;
        s_target_current <= it.target;
        s_sense_ch0 <= it.sense0;
        s_sense_ch1 <= it.sense1;
        s_sense_ch2 <= it.sense2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_transfer(it);
    endtask

    task automatic write_reg(hsc_reg_idx_t idx, logic [23:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic directed_run();
        // reset state shows on the first tick
        send_item(tick_item(16'd100, 16'd0, 16'd0, 16'd0));
        settle();
        write_reg(REG_DRIVE_MODE, 24'(MODE_FORWARD));
        write_reg(REG_PROP_GAIN, 24'h010000);
        write_reg(REG_INTEG_GAIN, 24'h000400);
        send_item(hall_item(3'd1));
        send_item(tick_item(16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        send_item(tick_item(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        for (int k = 0; k < 8; k++) send_item(hall_item(3'(k)));
        settle();
        write_reg(REG_DRIVE_MODE, 24'(MODE_BACKWARD));
        send_item(hall_item(3'd1));
        send_item(hall_item(3'd7));
        send_item(hall_item(3'd0));
        settle();
        // brake: kept, step back, step back again, step forward, kept twice
        write_reg(REG_DRIVE_MODE, 24'(MODE_BRAKE));
        send_item(hall_item(3'd1));
        send_item(hall_item(3'd5));
        send_item(hall_item(3'd1));
        send_item(hall_item(3'd6));
        send_item(hall_item(3'd3));
        send_item(hall_item(3'd7));
        settle();
        write_reg(REG_DRIVE_MODE, 24'(MODE_FREEWHEEL));
        send_item(hall_item(3'd2));
        send_item(random_tick());
    endtask

    task automatic random_phase(int p, int n_items);
        int pos;
        int dir;
        int pick;
        pos = $urandom_range(0, 5);
        dir = 1;
        settle();
        calm = (p == 6);
        write_reg(REG_DRIVE_MODE, 24'(hsc_mode_t'(p % 4)));
        if (p == 1) write_reg(REG_PROP_GAIN, 24'hFFFFFF);
        else if (p == 2) write_reg(REG_PROP_GAIN, 24'd0);
        else if ($urandom_range(0, 3) != 0) write_reg(REG_PROP_GAIN, pick_gain());
        if (p == 3) write_reg(REG_INTEG_GAIN, 24'hFFFFFF);
        else if (p == 4) write_reg(REG_INTEG_GAIN, 24'd0);
        else if ($urandom_range(0, 3) != 0) write_reg(REG_INTEG_GAIN, pick_gain());
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // sensor rotation, sometimes reversing
                if ($urandom_range(0, 9) == 0) dir = -dir;
                pos = (pos + dir + 6) % 6;
                send_item(hall_item(raw_for_index(pos)));
            end else if (pick < 87) begin
                send_item(random_tick());
            end else begin
                send_item(hall_item(3'($urandom())));
            end
        end
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_hall_bits = '0;
        s_target_current = '0;
        s_sense_ch0 = '0;
        s_sense_ch1 = '0;
        s_sense_ch2 = '0;
        m_ready = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        directed_run();
        for (int p = 0; p < 12; p++) random_phase(p, 110);
        settle();
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/hsc_pkg.sv
design/hsc_commute.sv
design/hall_six_step_commutator_pi.sv
verif/tb.sv
